// ----- rtl/aasc_pkg.sv -----
// Shared constants and types for the ADC average, scale and EMA conditioner.
package aasc_pkg;

    // Window store geometry
    localparam int MAX_ORDER = 16;
    localparam int SLOT_W    = $clog2(MAX_ORDER);
    localparam int ORDER_W   = $clog2(MAX_ORDER + 1);

    // Field widths
    localparam int SAMPLE_W  = 12;
    localparam int AVG_W     = 16;
    localparam int SMOOTH_W  = 32;
    localparam int SUM_W     = SAMPLE_W + SLOT_W;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int ORDER_REG_W = 5;
    localparam int NPTS_W      = 9;
    localparam int OFFSET_W    = 16;
    localparam int GAIN_W      = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_ORDER = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EMA_POINTS   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN         = 3'd3;

    localparam logic [ORDER_REG_W-1:0] ORDER_RESET  = 5'd10;
    localparam logic [NPTS_W-1:0]      NPTS_RESET   = 9'd100;
    localparam logic [OFFSET_W-1:0]    OFFSET_RESET = 16'd16;
    localparam logic [GAIN_W-1:0]      GAIN_RESET   = 24'd65536;

    localparam int EMA_MAX_POINTS = 350;

    // Shared divider: dividend, divisor and remainder widths
    localparam int NUM_W  = 34;
    localparam int DEN_W  = 9;
    localparam int REM_W  = 9;
    localparam int DCNT_W = 5;

    // Average dividend is sum*16 + order/2
    localparam int AVG_NUM_W     = SUM_W + 4;
    localparam int AVG_DIV_STEPS = (AVG_NUM_W + 1) / 2;
    localparam int EMA_DIV_STEPS = NUM_W / 2;

    // Datapath widths after the divider
    localparam int DIFF_W  = AVG_W + 1;
    localparam int PROD_W  = DIFF_W + GAIN_W;
    localparam int RND_W   = PROD_W - 4;
    localparam int DELTA_W = SMOOTH_W + 1;

    localparam logic [AVG_W-1:0] AVG_MAX = AVG_W'(16 * ((1 << SAMPLE_W) - 1));

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_AVG_DIV,
        ST_DIFF,
        ST_PROD,
        ST_SCALE,
        ST_DELTA,
        ST_EMA_LOAD,
        ST_EMA_DIV,
        ST_OUT
    } state_t;

endpackage

// ----- rtl/aasc_in_if.sv -----
// Sample channel: valid, ready and one raw converter sample per beat.
interface aasc_in_if;
    logic                          valid;
    logic                          ready;
    logic [aasc_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ----- rtl/aasc_out_if.sv -----
// Result channel: valid, ready, window average and smoothed value per beat.
interface aasc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [aasc_pkg::AVG_W-1:0]           window_average;
    logic signed [aasc_pkg::SMOOTH_W-1:0] smoothed_value;

    modport source (output valid, output window_average, output smoothed_value, input ready);
    modport sink   (input valid, input window_average, input smoothed_value, output ready);
endinterface

// ----- rtl/aasc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module aasc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/adc_average_scale_ema_conditioner_core.sv -----
// Top level of the ADC conditioner: window average, offset and gain, EMA smoothing.
//
//  channel   | dir | beat contents                         | handshake
//  ----------+-----+---------------------------------------+-------------------
//  samples   | in  | sample[11:0] unsigned raw             | valid/ready
//  results   | out | window_average[15:0] Q12.4,           | valid/ready
//            |     | smoothed_value[31:0] signed Q16.16    |
//  cfg       | in  | cfg_we, cfg_index[2:0], cfg_data[23:0]| write on cfg_we
//
//  For each sample the window sum reads one RAM entry per cycle, then a
//  shared restoring divider retires two quotient bits per cycle, first for
//  the mean and then for the EMA step.
//  Reset clears the per-slot valid bits at once; never-written slots add
//  zero to the sum, so no clearing pass runs and a sample is taken right after reset.
//  The result sits in an output register; the next sample is accepted while it
//  waits, and a finished result holds in ST_OUT until that register frees up.
module adc_average_scale_ema_conditioner_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [aasc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [aasc_pkg::CFG_DATA_W-1:0]     cfg_data,
    aasc_in_if.sink                             samples,
    aasc_out_if.source                          results
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [aasc_pkg::ORDER_REG_W-1:0]  window_order_reg;
    logic [aasc_pkg::NPTS_W-1:0]       ema_points_reg;
    logic [aasc_pkg::OFFSET_W-1:0]     offset_reg;
    logic signed [aasc_pkg::GAIN_W-1:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_order_reg <= aasc_pkg::ORDER_RESET;
            ema_points_reg   <= aasc_pkg::NPTS_RESET;
            offset_reg       <= aasc_pkg::OFFSET_RESET;
            gain_reg         <= $signed(aasc_pkg::GAIN_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aasc_pkg::CFG_WINDOW_ORDER: window_order_reg <= cfg_data[aasc_pkg::ORDER_REG_W-1:0];
                aasc_pkg::CFG_EMA_POINTS:   ema_points_reg   <= cfg_data[aasc_pkg::NPTS_W-1:0];
                aasc_pkg::CFG_OFFSET:       offset_reg       <= cfg_data[aasc_pkg::OFFSET_W-1:0];
                aasc_pkg::CFG_GAIN:         gain_reg         <= $signed(cfg_data[aasc_pkg::GAIN_W-1:0]);
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // Clamp order to 1..MAX_ORDER and N to 1..350
    logic [aasc_pkg::ORDER_W-1:0] order_use;
    logic [aasc_pkg::NPTS_W-1:0]  npts_use;
    logic [aasc_pkg::DEN_W-1:0]   den_use;

    always_comb
    begin
        if (window_order_reg == '0)
            order_use = aasc_pkg::ORDER_W'(1);
        else if (int'(window_order_reg) > aasc_pkg::MAX_ORDER)
            order_use = aasc_pkg::ORDER_W'(aasc_pkg::MAX_ORDER);
        else
            order_use = aasc_pkg::ORDER_W'(window_order_reg);

        if (ema_points_reg == '0)
            npts_use = aasc_pkg::NPTS_W'(1);
        else if (int'(ema_points_reg) > aasc_pkg::EMA_MAX_POINTS)
            npts_use = aasc_pkg::NPTS_W'(aasc_pkg::EMA_MAX_POINTS);
        else
            npts_use = ema_points_reg;

        den_use = aasc_pkg::DEN_W'(npts_use + aasc_pkg::NPTS_W'(1));
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    aasc_pkg::state_t state_reg, state_next;

    // Window bookkeeping: write slot, per-slot valid bits, sum
    logic [aasc_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [aasc_pkg::MAX_ORDER-1:0] valid_reg, valid_next;
    logic [aasc_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [aasc_pkg::ORDER_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic                           rd_pend_reg, rd_pend_next;
    logic                           rd_hit_reg, rd_hit_next;

    // Shared divider
    logic [aasc_pkg::NUM_W-1:0]  div_num_reg, div_num_next;
    logic [aasc_pkg::DEN_W-1:0]  div_den_reg, div_den_next;
    logic [aasc_pkg::REM_W-1:0]  div_rem_reg, div_rem_next;
    logic [aasc_pkg::NUM_W-1:0]  div_q_reg, div_q_next;
    logic [aasc_pkg::DCNT_W-1:0] div_cnt_reg, div_cnt_next;

    // Arithmetic pipeline registers
    logic [aasc_pkg::AVG_W-1:0]            avg_reg, avg_next;
    logic signed [aasc_pkg::DIFF_W-1:0]    diff_reg, diff_next;
    logic signed [aasc_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic signed [aasc_pkg::SMOOTH_W-1:0]  scaled_reg, scaled_next;
    logic signed [aasc_pkg::DELTA_W-1:0]   delta_reg, delta_next;
    logic signed [aasc_pkg::SMOOTH_W-1:0]  prev_reg, prev_next;

    // Output register
    logic                                  res_valid_reg, res_valid_next;
    logic [aasc_pkg::AVG_W-1:0]            res_avg_reg, res_avg_next;
    logic signed [aasc_pkg::SMOOTH_W-1:0]  res_smooth_reg, res_smooth_next;

    // ------------------------------------------------------------------
    // Window RAM
    // ------------------------------------------------------------------
    logic                          in_accept;
    logic [aasc_pkg::SAMPLE_W-1:0] ram_rdata;

    assign samples.ready = (state_reg == aasc_pkg::ST_IDLE);
    assign in_accept     = samples.valid && samples.ready;

    aasc_ram #(
        .WIDTH (aasc_pkg::SAMPLE_W),
        .DEPTH (aasc_pkg::MAX_ORDER)
    ) u_window_ram (
        .clk   (clk),
        .we    (in_accept),
        .waddr (slot_reg),
        .wdata (samples.sample),
        .raddr (rd_cnt_reg[aasc_pkg::SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Divider step: two restoring iterations per cycle
    // ------------------------------------------------------------------
    logic [aasc_pkg::NUM_W-1:0] step_num;
    logic [aasc_pkg::REM_W-1:0] step_rem;
    logic [aasc_pkg::NUM_W-1:0] step_q;

    always_comb
    begin
        logic [aasc_pkg::REM_W:0] trial;
        step_num = div_num_reg;
        step_rem = div_rem_reg;
        step_q   = div_q_reg;
        for (int k = 0; k < 2; k++)
        begin
            trial    = {step_rem, step_num[aasc_pkg::NUM_W-1]};
            step_num = {step_num[aasc_pkg::NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, div_den_reg})
            begin
                step_rem = aasc_pkg::REM_W'(trial - {1'b0, div_den_reg});
                step_q   = {step_q[aasc_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                step_rem = trial[aasc_pkg::REM_W-1:0];
                step_q   = {step_q[aasc_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    // Saturate a rounded value to signed 32 bits
    function automatic logic signed [aasc_pkg::SMOOTH_W-1:0] sat32(
        input logic signed [aasc_pkg::RND_W-1:0] v
    );
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[aasc_pkg::RND_W-1:aasc_pkg::SMOOTH_W-1];
        hi_zeros = ~|v[aasc_pkg::RND_W-1:aasc_pkg::SMOOTH_W-1];
        if (hi_ones || hi_zeros)
            return v[aasc_pkg::SMOOTH_W-1:0];
        else if (v[aasc_pkg::RND_W-1])
            return {1'b1, {(aasc_pkg::SMOOTH_W-1){1'b0}}};
        else
            return {1'b0, {(aasc_pkg::SMOOTH_W-1){1'b1}}};
    endfunction

    // ------------------------------------------------------------------
    // Next state and datapath
    // ------------------------------------------------------------------
    logic [aasc_pkg::ORDER_W-1:0]   slot_inc;
    logic [aasc_pkg::AVG_NUM_W-1:0] avg_dividend;
    logic signed [aasc_pkg::RND_W-1:0]   rnd_value;
    logic [aasc_pkg::DELTA_W-1:0]        delta_mag;
    logic [aasc_pkg::DELTA_W:0]          step_signed;
    logic signed [aasc_pkg::DELTA_W:0]   y_wide;
    logic signed [aasc_pkg::SMOOTH_W-1:0] y_value;

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        valid_next     = valid_reg;
        sum_next       = sum_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_pend_next   = rd_pend_reg;
        rd_hit_next    = rd_hit_reg;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        div_rem_next   = div_rem_reg;
        div_q_next     = div_q_reg;
        div_cnt_next   = div_cnt_reg;
        avg_next       = avg_reg;
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        scaled_next    = scaled_reg;
        delta_next     = delta_reg;
        prev_next      = prev_reg;
        res_valid_next = res_valid_reg && !results.ready;
        res_avg_next   = res_avg_reg;
        res_smooth_next = res_smooth_reg;

        slot_inc = aasc_pkg::ORDER_W'(slot_reg) + aasc_pkg::ORDER_W'(1);

        avg_dividend = '0;

        rnd_value = aasc_pkg::RND_W'((prod_reg + aasc_pkg::PROD_W'(8)) >>> 4);

        delta_mag = delta_reg[aasc_pkg::DELTA_W-1] ? aasc_pkg::DELTA_W'(-delta_reg)
                                                   : aasc_pkg::DELTA_W'(delta_reg);

        step_signed = delta_reg[aasc_pkg::DELTA_W-1]
                    ? -{1'b0, div_q_reg[aasc_pkg::DELTA_W-1:0]}
                    :  {1'b0, div_q_reg[aasc_pkg::DELTA_W-1:0]};
        y_wide  = $signed({{2{prev_reg[aasc_pkg::SMOOTH_W-1]}}, prev_reg}) + $signed(step_signed);
        y_value = sat32(aasc_pkg::RND_W'(y_wide));

        unique case (state_reg)
            aasc_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    // Sample lands in the RAM at this edge; mark the slot live
                    valid_next[slot_reg] = 1'b1;
                    if (slot_inc >= order_use)
                        slot_next = '0;
                    else
                        slot_next = slot_inc[aasc_pkg::SLOT_W-1:0];
                    sum_next     = '0;
                    rd_cnt_next  = '0;
                    rd_pend_next = 1'b0;
                    state_next   = aasc_pkg::ST_READ;
                end
            end

            aasc_pkg::ST_READ:
            begin
                // Accumulate the entry read last cycle; dead slots add zero
                if (rd_pend_reg && rd_hit_reg)
                    sum_next = sum_reg + aasc_pkg::SUM_W'(ram_rdata);
                if (rd_cnt_reg < order_use)
                begin
                    rd_cnt_next  = rd_cnt_reg + aasc_pkg::ORDER_W'(1);
                    rd_pend_next = 1'b1;
                    rd_hit_next  = valid_reg[rd_cnt_reg[aasc_pkg::SLOT_W-1:0]];
                end
                else
                begin
                    // Last entry is folded in above; dividend is sum*16 + order/2
                    avg_dividend = aasc_pkg::AVG_NUM_W'({sum_next, 4'b0000})
                                 + aasc_pkg::AVG_NUM_W'(order_use >> 1);
                    rd_pend_next = 1'b0;
                    div_num_next = aasc_pkg::NUM_W'(avg_dividend)
                                   << (aasc_pkg::NUM_W - 2 * aasc_pkg::AVG_DIV_STEPS);
                    div_den_next = aasc_pkg::DEN_W'(order_use);
                    div_rem_next = '0;
                    div_q_next   = '0;
                    div_cnt_next = aasc_pkg::DCNT_W'(aasc_pkg::AVG_DIV_STEPS);
                    state_next   = aasc_pkg::ST_AVG_DIV;
                end
            end

            aasc_pkg::ST_AVG_DIV, aasc_pkg::ST_EMA_DIV:
            begin
                div_num_next = step_num;
                div_rem_next = step_rem;
                div_q_next   = step_q;
                div_cnt_next = div_cnt_reg - aasc_pkg::DCNT_W'(1);
                if (div_cnt_reg == aasc_pkg::DCNT_W'(1))
                begin
                    if (state_reg == aasc_pkg::ST_AVG_DIV)
                        state_next = aasc_pkg::ST_DIFF;
                    else
                        state_next = aasc_pkg::ST_OUT;
                end
            end

            aasc_pkg::ST_DIFF:
            begin
                avg_next  = div_q_reg[aasc_pkg::AVG_W-1:0];
                diff_next = $signed({1'b0, div_q_reg[aasc_pkg::AVG_W-1:0]})
                          - $signed({1'b0, offset_reg});
                state_next = aasc_pkg::ST_PROD;
            end

            aasc_pkg::ST_PROD:
            begin
                prod_next  = diff_reg * gain_reg;
                state_next = aasc_pkg::ST_SCALE;
            end

            aasc_pkg::ST_SCALE:
            begin
                // Round Q.20 to Q16.16 with ties up, then saturate
                scaled_next = sat32(rnd_value);
                state_next  = aasc_pkg::ST_DELTA;
            end

            aasc_pkg::ST_DELTA:
            begin
                delta_next = $signed({scaled_reg[aasc_pkg::SMOOTH_W-1], scaled_reg})
                           - $signed({prev_reg[aasc_pkg::SMOOTH_W-1], prev_reg});
                state_next = aasc_pkg::ST_EMA_LOAD;
            end

            aasc_pkg::ST_EMA_LOAD:
            begin
                // step = (2*|delta| + den/2) / den, sign restored at the end
                div_num_next = aasc_pkg::NUM_W'({delta_mag, 1'b0})
                             + aasc_pkg::NUM_W'(den_use >> 1);
                div_den_next = den_use;
                div_rem_next = '0;
                div_q_next   = '0;
                div_cnt_next = aasc_pkg::DCNT_W'(aasc_pkg::EMA_DIV_STEPS);
                state_next   = aasc_pkg::ST_EMA_DIV;
            end

            aasc_pkg::ST_OUT:
            begin
                // Hold until the output register is free
                if (!res_valid_reg || results.ready)
                begin
                    res_valid_next  = 1'b1;
                    res_avg_next    = avg_reg;
                    res_smooth_next = y_value;
                    prev_next       = y_value;
                    state_next      = aasc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = aasc_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aasc_pkg::ST_IDLE;
            slot_reg      <= '0;
            valid_reg     <= '0;
            sum_reg       <= '0;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            div_cnt_reg   <= '0;
            prev_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            valid_reg     <= valid_next;
            sum_reg       <= sum_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            div_cnt_reg   <= div_cnt_next;
            prev_reg      <= prev_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_hit_reg     <= rd_hit_next;
        div_num_reg    <= div_num_next;
        div_den_reg    <= div_den_next;
        div_rem_reg    <= div_rem_next;
        div_q_reg      <= div_q_next;
        avg_reg        <= avg_next;
        diff_reg       <= diff_next;
        prod_reg       <= prod_next;
        scaled_reg     <= scaled_next;
        delta_reg      <= delta_next;
        res_avg_reg    <= res_avg_next;
        res_smooth_reg <= res_smooth_next;
    end

    assign results.valid          = res_valid_reg;
    assign results.window_average = res_avg_reg;
    assign results.smoothed_value = res_smooth_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == aasc_pkg::ST_OUT))
        else $error("result became valid outside the output step");

    a_div_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aasc_pkg::ST_AVG_DIV || state_reg == aasc_pkg::ST_EMA_DIV)
        |-> div_cnt_reg != '0)
        else $error("divider running with an empty step count");

    a_read_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aasc_pkg::ST_READ) |-> rd_cnt_reg <= order_use)
        else $error("window read counter ran past the order");

    a_slot_marked: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> valid_reg[$past(slot_reg)])
        else $error("written slot not marked valid");

    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_avg_reg <= aasc_pkg::AVG_MAX)
        else $error("window average above full-scale mean");
`endif

endmodule
